// ===== rtl/nnr_pkg.sv =====
// Package for the nearest-neighbor route block: beat payload types, mode and status codes,
// microcode word layout and the step addresses of the route program.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nnr_pkg;

   // Fixed field widths of the beats and of the step address.
   localparam int LOC_W   = 5;
   localparam int DIN_W   = 16;
   localparam int TOTAL_W = 20;
   localparam int UPC_W   = 4;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [1:0] {
      MODE_BASE   = 2'd0,
      MODE_PAIR   = 2'd1,
      MODE_SELECT = 2'd2,
      MODE_START  = 2'd3
   } nnr_mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNREACH = 2'd1,
      ST_EMPTY   = 2'd2
   } nnr_status_type;

   typedef struct packed {
      nnr_mode_type     mode;
      logic [LOC_W-1:0] loc_a;
      logic [LOC_W-1:0] loc_b;
      logic [DIN_W-1:0] distance;
      logic             from_base;
   } nnr_req_type;

   typedef struct packed {
      logic [LOC_W-1:0]   stop_location;
      logic [TOTAL_W-1:0] distance_so_far;
      logic               last_stop;
      nnr_status_type     status;
   } nnr_rsp_type;

   // Datapath operations, one per microcode step.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_IDLE,
      OP_INIT,
      OP_READ,
      OP_CMP,
      OP_TAKE,
      OP_NEXT,
      OP_FIRST,
      OP_FAIL,
      OP_EMPTY
   } nnr_op_type;

   // Jump conditions; a step jumps to its target when its condition holds.
   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_CLR_BUSY,
      CND_NO_START,
      CND_EMPTY,
      CND_NOT_FB,
      CND_MORE,
      CND_NO_BEST,
      CND_OUT_BUSY,
      CND_ROUTE_DONE
   } nnr_cond_type;

   typedef struct packed {
      nnr_op_type       op;
      nnr_cond_type     cond;
      logic [UPC_W-1:0] target;
      logic             accept;
   } nnr_uword_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      nnr_op_type op;
      logic       accept;
   } nnr_ctl_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic clr_busy;
      logic start;
      logic empty;
      logic not_fb;
      logic more;
      logic no_best;
      logic out_busy;
      logic route_done;
   } nnr_flag_type;

   // Step addresses of the route program.
   localparam logic [UPC_W-1:0] U_CLEAR   = 4'd0;
   localparam logic [UPC_W-1:0] U_IDLE    = 4'd1;
   localparam logic [UPC_W-1:0] U_START   = 4'd2;
   localparam logic [UPC_W-1:0] U_ORIGIN  = 4'd3;
   localparam logic [UPC_W-1:0] U_READ    = 4'd4;
   localparam logic [UPC_W-1:0] U_CMP     = 4'd5;
   localparam logic [UPC_W-1:0] U_CHECK   = 4'd6;
   localparam logic [UPC_W-1:0] U_WAIT    = 4'd7;
   localparam logic [UPC_W-1:0] U_TAKE    = 4'd8;
   localparam logic [UPC_W-1:0] U_NEXT    = 4'd9;
   localparam logic [UPC_W-1:0] U_FREAD   = 4'd10;
   localparam logic [UPC_W-1:0] U_FIRST   = 4'd11;
   localparam logic [UPC_W-1:0] U_FAIL_W  = 4'd12;
   localparam logic [UPC_W-1:0] U_FAIL    = 4'd13;
   localparam logic [UPC_W-1:0] U_EMPTY_W = 4'd14;
   localparam logic [UPC_W-1:0] U_EMPTY   = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/nearest_neighbor_route_of_selection_top.sv =====
// Top level of the nearest-neighbor route block: joins the microcode sequencer and the
// datapath. Depends on nnr_pkg, nnr_seq and nnr_dp.
//
//   Channel | Ports                              | Direction | Beat
//   --------+------------------------------------+-----------+------------------------------
//   request | req_valid, req_stall, req_data     | in        | load, selection edit or start
//   result  | rsp_valid, rsp_stall, rsp_data     | out       | one stop of the route
//
// A start beat walks the selection once per stop, reading every selected position in turn
// through the single read port of the pair store.
// After reset the pair store is swept to "none", all NUM_LOCATIONS*NUM_LOCATIONS entries
// (1024 by default), with req_stall high. A stalled result holds the sequencer before the
// next stop is written; the last result of a route may wait while new request beats arrive.
`default_nettype none

module nearest_neighbor_route_of_selection_top #(
   parameter int NUM_LOCATIONS     = 32,
   parameter int MAX_SELECTED      = 16,
   parameter int DIST_BITS         = 16,
   parameter int NO_ROUTE_SENTINEL = 63994
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  nnr_pkg::nnr_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output nnr_pkg::nnr_rsp_type rsp_data
);
   import nnr_pkg::*;

   nnr_ctl_type  ctl;
   nnr_flag_type flags;

   nnr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   nnr_dp #(
      .NUM_LOCATIONS     (NUM_LOCATIONS),
      .MAX_SELECTED      (MAX_SELECTED),
      .DIST_BITS         (DIST_BITS),
      .NO_ROUTE_SENTINEL (NO_ROUTE_SENTINEL)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .flags     (flags),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // Request beats are taken only at the idle step of the program.
   assign req_stall = !ctl.accept;

   // An empty or unreachable result always closes its route.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last_stop)
      else $error("non-ok result without last_stop");

   // No result is produced while the pair store is being swept.
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_CLEAR |-> !rsp_valid)
      else $error("result during clearing pass");

   // A new result is only written while the block is working on a start beat.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while block was idle");

endmodule

`default_nettype wire

// ===== rtl/nnr_seq.sv =====
// Microcode sequencer: the route program in a read-only table, a step counter and
// conditional jumps. Depends on nnr_pkg.
`default_nettype none

module nnr_seq (
   input  wire                   clock,
   input  wire                   reset,
   input  nnr_pkg::nnr_flag_type flags,
   output nnr_pkg::nnr_ctl_type  ctl
);
   import nnr_pkg::*;

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   nnr_uword_type    uword;
   logic             hit;

   // Program table: operation, jump condition, jump target, input accepted.
   function automatic nnr_uword_type rom_word(input logic [UPC_W-1:0] addr);
      case (addr)
         U_CLEAR:   rom_word = '{op: OP_CLEAR, cond: CND_CLR_BUSY,   target: U_CLEAR,   accept: 1'b0};
         U_IDLE:    rom_word = '{op: OP_IDLE,  cond: CND_NO_START,   target: U_IDLE,    accept: 1'b1};
         U_START:   rom_word = '{op: OP_INIT,  cond: CND_EMPTY,      target: U_EMPTY_W, accept: 1'b0};
         U_ORIGIN:  rom_word = '{op: OP_NOP,   cond: CND_NOT_FB,     target: U_FREAD,   accept: 1'b0};
         U_READ:    rom_word = '{op: OP_READ,  cond: CND_NEVER,      target: U_READ,    accept: 1'b0};
         U_CMP:     rom_word = '{op: OP_CMP,   cond: CND_MORE,       target: U_READ,    accept: 1'b0};
         U_CHECK:   rom_word = '{op: OP_NOP,   cond: CND_NO_BEST,    target: U_FAIL_W,  accept: 1'b0};
         U_WAIT:    rom_word = '{op: OP_NOP,   cond: CND_OUT_BUSY,   target: U_WAIT,    accept: 1'b0};
         U_TAKE:    rom_word = '{op: OP_TAKE,  cond: CND_ROUTE_DONE, target: U_IDLE,    accept: 1'b0};
         U_NEXT:    rom_word = '{op: OP_NEXT,  cond: CND_ALWAYS,     target: U_READ,    accept: 1'b0};
         U_FREAD:   rom_word = '{op: OP_READ,  cond: CND_NEVER,      target: U_FREAD,   accept: 1'b0};
         U_FIRST:   rom_word = '{op: OP_FIRST, cond: CND_ALWAYS,     target: U_WAIT,    accept: 1'b0};
         U_FAIL_W:  rom_word = '{op: OP_NOP,   cond: CND_OUT_BUSY,   target: U_FAIL_W,  accept: 1'b0};
         U_FAIL:    rom_word = '{op: OP_FAIL,  cond: CND_ALWAYS,     target: U_IDLE,    accept: 1'b0};
         U_EMPTY_W: rom_word = '{op: OP_NOP,   cond: CND_OUT_BUSY,   target: U_EMPTY_W, accept: 1'b0};
         U_EMPTY:   rom_word = '{op: OP_EMPTY, cond: CND_ALWAYS,     target: U_IDLE,    accept: 1'b0};
         default:   rom_word = '{op: OP_NOP,   cond: CND_ALWAYS,     target: U_IDLE,    accept: 1'b0};
      endcase
   endfunction

   // Decode the current step and pick the next one.
   always_comb begin
      uword = rom_word(upc_ff);
      case (uword.cond)
         CND_NEVER:      hit = 1'b0;
         CND_ALWAYS:     hit = 1'b1;
         CND_CLR_BUSY:   hit = flags.clr_busy;
         CND_NO_START:   hit = !flags.start;
         CND_EMPTY:      hit = flags.empty;
         CND_NOT_FB:     hit = flags.not_fb;
         CND_MORE:       hit = flags.more;
         CND_NO_BEST:    hit = flags.no_best;
         CND_OUT_BUSY:   hit = flags.out_busy;
         CND_ROUTE_DONE: hit = flags.route_done;
         default:        hit = 1'b1;
      endcase
      upc_in     = hit ? uword.target : upc_ff + 1'b1;
      ctl.op     = uword.op;
      ctl.accept = uword.accept;
   end

   // Step counter; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/nnr_dp.sv =====
// Datapath of the route block: distance stores, selection list, nearest-candidate scan
// registers, running total and the result register. Driven by nnr_seq; depends on nnr_pkg.
`default_nettype none

module nnr_dp #(
   parameter int NUM_LOCATIONS     = 32,
   parameter int MAX_SELECTED      = 16,
   parameter int DIST_BITS         = 16,
   parameter int NO_ROUTE_SENTINEL = 63994
) (
   input  wire                   clock,
   input  wire                   reset,
   input  nnr_pkg::nnr_ctl_type  ctl,
   output nnr_pkg::nnr_flag_type flags,
   input  wire                   req_valid,
   input  nnr_pkg::nnr_req_type  req_data,
   output logic                  rsp_valid,
   output nnr_pkg::nnr_rsp_type  rsp_data,
   input  wire                   rsp_stall
);
   import nnr_pkg::*;

   localparam int LW = $clog2(NUM_LOCATIONS);
   localparam int AW = $clog2(NUM_LOCATIONS * NUM_LOCATIONS);
   localparam int PW = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;
   localparam int CW = $clog2(MAX_SELECTED + 1);
   localparam int MS = MAX_SELECTED;
   localparam int LAST_ADDR = NUM_LOCATIONS * NUM_LOCATIONS - 1;
   localparam logic [DIST_BITS-1:0] NONE_VAL = DIST_BITS'(65535);

   // Stores.
   logic [DIST_BITS-1:0] pair_mem [NUM_LOCATIONS*NUM_LOCATIONS];
   logic [DIST_BITS-1:0] base_mem [NUM_LOCATIONS];
   logic [LW-1:0]        sel_mem  [MAX_SELECTED];
   logic [NUM_LOCATIONS-1:0] base_vld_ff, base_vld_in;

   // Control and scan registers.
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [MS-1:0]        mask_ff, mask_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [LW-1:0]        cur_ff, cur_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [PW-1:0]        best_pos_ff, best_pos_in;
   logic [LW-1:0]        best_loc_ff, best_loc_in;
   logic [DIST_BITS-1:0] best_d_ff, best_d_in;
   logic                 have_best_ff, have_best_in;
   logic                 at_base_ff, at_base_in;
   logic                 out_vld_ff, out_vld_in;
   nnr_rsp_type          out_ff, out_in;

   // Read registers of the scan.
   logic [LW-1:0]        loc_rd_ff;
   logic [DIST_BITS-1:0] base_rd_ff;
   logic [DIST_BITS-1:0] pair_rd_ff;

   logic                 load_acc;
   logic                 a_ok, b_ok;
   logic [DIST_BITS-1:0] dist_w;
   logic                 pw_en;
   logic [AW-1:0]        pw_addr;
   logic [DIST_BITS-1:0] pw_data;
   logic [LW-1:0]        sel_loc;
   logic [AW-1:0]        pr_addr;
   logic [DIST_BITS-1:0] cand_d;
   logic                 better;
   logic [MS-1:0]        mask_left;
   logic [TOTAL_W:0]     sum;

   always_comb begin
      load_acc = ctl.accept && req_valid;
      a_ok     = 32'(req_data.loc_a) < NUM_LOCATIONS;
      b_ok     = 32'(req_data.loc_b) < NUM_LOCATIONS;
      dist_w   = DIST_BITS'(req_data.distance);

      // Single write port of the pair store: clearing pass or a pair load.
      pw_en   = (ctl.op == OP_CLEAR) ||
                (load_acc && req_data.mode == MODE_PAIR && a_ok && b_ok);
      pw_addr = (ctl.op == OP_CLEAR) ? clr_cnt_ff :
                AW'(32'(req_data.loc_a) * NUM_LOCATIONS + 32'(req_data.loc_b));
      pw_data = (ctl.op == OP_CLEAR) ? NONE_VAL : dist_w;

      // Candidate at the scan position and its distance from the current stop.
      sel_loc = sel_mem[pos_ff];
      pr_addr = AW'(32'(cur_ff) * NUM_LOCATIONS + 32'(sel_loc));

      // Compare the fetched candidate; strictly smaller wins, so ties keep the earliest.
      cand_d = at_base_ff ? base_rd_ff : pair_rd_ff;
      better = mask_ff[pos_ff] && (32'(cand_d) < 32'(NO_ROUTE_SENTINEL)) &&
               (!have_best_ff || cand_d < best_d_ff);

      mask_left = mask_ff & ~(MS'(1) << best_pos_ff);
      sum       = (TOTAL_W+1)'(total_ff) + (TOTAL_W+1)'(best_d_ff);

      // Status toward the sequencer.
      flags.clr_busy   = 32'(clr_cnt_ff) != LAST_ADDR;
      flags.start      = req_valid && req_data.mode == MODE_START;
      flags.empty      = count_ff == '0;
      flags.not_fb     = !at_base_ff;
      flags.more       = (32'(pos_ff) + 32'd1) < 32'(count_ff);
      flags.no_best    = !have_best_ff;
      flags.out_busy   = out_vld_ff && rsp_stall;
      flags.route_done = mask_left == '0;
   end

   // Next values of the control and scan registers.
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      base_vld_in  = base_vld_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      total_in     = total_ff;
      best_pos_in  = best_pos_ff;
      best_loc_in  = best_loc_ff;
      best_d_in    = best_d_ff;
      have_best_in = have_best_ff;
      at_base_in   = at_base_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && rsp_stall;

      case (ctl.op)
         OP_CLEAR: begin
            clr_cnt_in = AW'(32'(clr_cnt_ff) + 32'd1);
         end
         OP_IDLE: begin
            if (load_acc) begin
               case (req_data.mode)
                  MODE_BASE: begin
                     if (a_ok) begin
                        base_vld_in[LW'(req_data.loc_a)] = 1'b1;
                     end
                  end
                  MODE_SELECT: begin
                     if (req_data.from_base) begin
                        count_in = '0;
                     end else if (32'(count_ff) < MAX_SELECTED && a_ok) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_START: begin
                     at_base_in = req_data.from_base;
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_INIT: begin
            for (int k = 0; k < MS; k++) begin
               mask_in[k] = 32'(k) < 32'(count_ff);
            end
            total_in     = '0;
            pos_in       = '0;
            have_best_in = 1'b0;
         end
         OP_CMP: begin
            if (better) begin
               best_pos_in  = pos_ff;
               best_loc_in  = loc_rd_ff;
               best_d_in    = cand_d;
               have_best_in = 1'b1;
            end
            pos_in = PW'(32'(pos_ff) + 32'd1);
         end
         OP_FIRST: begin
            best_pos_in  = '0;
            best_loc_in  = loc_rd_ff;
            best_d_in    = '0;
            have_best_in = 1'b1;
         end
         OP_TAKE: begin
            total_in   = (sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            cur_in     = best_loc_ff;
            mask_in    = mask_left;
            out_vld_in = 1'b1;
            out_in.stop_location   = LOC_W'(best_loc_ff);
            out_in.distance_so_far = total_in;
            out_in.last_stop       = mask_left == '0;
            out_in.status          = ST_OK;
         end
         OP_NEXT: begin
            pos_in       = '0;
            have_best_in = 1'b0;
            at_base_in   = 1'b0;
         end
         OP_FAIL: begin
            out_vld_in = 1'b1;
            out_in.stop_location   = at_base_ff ? '0 : LOC_W'(cur_ff);
            out_in.distance_so_far = total_ff;
            out_in.last_stop       = 1'b1;
            out_in.status          = ST_UNREACH;
         end
         OP_EMPTY: begin
            out_vld_in = 1'b1;
            out_in.stop_location   = '0;
            out_in.distance_so_far = '0;
            out_in.last_stop       = 1'b1;
            out_in.status          = ST_EMPTY;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         base_vld_ff  <= '0;
         count_ff     <= '0;
         mask_ff      <= '0;
         pos_ff       <= '0;
         cur_ff       <= '0;
         total_ff     <= '0;
         have_best_ff <= 1'b0;
         at_base_ff   <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         base_vld_ff  <= base_vld_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         pos_ff       <= pos_in;
         cur_ff       <= cur_in;
         total_ff     <= total_in;
         have_best_ff <= have_best_in;
         at_base_ff   <= at_base_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // Payload registers of the best candidate and the result.
   always_ff @(posedge clock) begin
      best_pos_ff <= best_pos_in;
      best_loc_ff <= best_loc_in;
      best_d_ff   <= best_d_in;
      out_ff      <= out_in;
   end

   // Pair distance store: one write port, registered read.
   always_ff @(posedge clock) begin
      if (pw_en) begin
         pair_mem[pw_addr] <= pw_data;
      end
      if (ctl.op == OP_READ) begin
         pair_rd_ff <= pair_mem[pr_addr];
      end
   end

   // Base distance store; an entry never loaded reads as none.
   always_ff @(posedge clock) begin
      if (load_acc && req_data.mode == MODE_BASE && a_ok) begin
         base_mem[LW'(req_data.loc_a)] <= dist_w;
      end
      if (ctl.op == OP_READ) begin
         base_rd_ff <= base_vld_ff[sel_loc] ? base_mem[sel_loc] : NONE_VAL;
      end
   end

   // Selection list: appended at the fill count, read at the scan position.
   always_ff @(posedge clock) begin
      if (load_acc && req_data.mode == MODE_SELECT && !req_data.from_base &&
          32'(count_ff) < MAX_SELECTED && a_ok) begin
         sel_mem[count_ff[PW-1:0]] <= LW'(req_data.loc_a);
      end
      if (ctl.op == OP_READ) begin
         loc_rd_ff <= sel_loc;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
